// ===== hdl/sal_pkg.sv =====
package sal_pkg;

   localparam int DEF_MAX_LEN      = 1024;
   localparam int DEF_TOKEN_VALUES = 65536;

   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_READ = 1'b1;

   typedef enum logic [5:0] {
      ST_IDLE, ST_RD_ADDR, ST_RD_DATA, ST_INIT, ST_CLR,
      ST_CNT_A, ST_CNT_K, ST_CNT_B, ST_CNT_C,
      ST_SUM_A, ST_SUM_B,
      ST_DIS_A, ST_DIS_K, ST_DIS_B, ST_DIS_C,
      ST_RNK_A, ST_RNK_B, ST_RNK_C, ST_CHK,
      ST_SCR_T, ST_SCR_A, ST_SCR_B,
      ST_NEW_A, ST_NEW_B, ST_NEW_C, ST_NEW_D,
      ST_CPY_A, ST_CPY_B,
      ST_KAS_A, ST_KAS_B, ST_KAS_J, ST_KAS_T1, ST_KAS_T2, ST_KAS_T3,
      ST_KAS_W, ST_KAS_END
   } step_type;

   typedef struct packed {
      step_type step;
      logic     first;      // initial pass keyed on tokens
      logic     req_ready;
   } cmd_type;

   typedef struct packed {
      logic req_valid;
      logic req_action;
      logic req_eos;
      logic rsp_free;
      logic last;           // loop index at its final value
      logic zero;           // loop index is zero
      logic more_pass;      // another doubling pass is needed
      logic kas_skip;       // suffix sits at the last rank
      logic kas_more;       // both suffixes still have tokens
      logic kas_eq;         // compared tokens match
   } status_type;

endpackage

// ===== hdl/sal_req_if.sv =====
interface sal_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic [15:0] token;
   logic        end_of_string;
   logic [9:0]  rank;

   modport source (output valid, action, token, end_of_string, rank, input ready);
   modport sink   (input valid, action, token, end_of_string, rank, output ready);
endinterface

// ===== hdl/sal_rsp_if.sv =====
interface sal_rsp_if;
   logic       valid;
   logic       ready;
   logic [9:0] position;
   logic [9:0] common_prefix;
   logic       in_range;

   modport source (output valid, position, common_prefix, in_range, input ready);
   modport sink   (input valid, position, common_prefix, in_range, output ready);
endinterface

// ===== hdl/sal_ram.sv =====
module sal_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/sal_ctrl.sv =====
module sal_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  sal_pkg::status_type stat,
   output sal_pkg::cmd_type    cmd
);

   sal_pkg::step_type state_ff, state_in;
   logic first_ff, first_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sal_pkg::ST_IDLE: begin
            if (stat.req_valid) begin
               if (stat.req_action == sal_pkg::ACT_READ) begin
                  state_in = sal_pkg::ST_RD_ADDR;
               end else if (stat.req_eos) begin
                  state_in = sal_pkg::ST_INIT;
               end
            end
         end
         sal_pkg::ST_RD_ADDR: state_in = sal_pkg::ST_RD_DATA;
         sal_pkg::ST_RD_DATA: if (stat.rsp_free) state_in = sal_pkg::ST_IDLE;
         sal_pkg::ST_INIT:    state_in = sal_pkg::ST_CLR;
         sal_pkg::ST_CLR:     if (stat.last) state_in = sal_pkg::ST_CNT_A;
         sal_pkg::ST_CNT_A:
            state_in = first_ff ? sal_pkg::ST_CNT_B : sal_pkg::ST_CNT_K;
         sal_pkg::ST_CNT_K:   state_in = sal_pkg::ST_CNT_B;
         sal_pkg::ST_CNT_B:   state_in = sal_pkg::ST_CNT_C;
         sal_pkg::ST_CNT_C:
            state_in = stat.last ? sal_pkg::ST_SUM_A : sal_pkg::ST_CNT_A;
         sal_pkg::ST_SUM_A:   state_in = sal_pkg::ST_SUM_B;
         sal_pkg::ST_SUM_B:
            state_in = stat.last ? sal_pkg::ST_DIS_A : sal_pkg::ST_SUM_A;
         sal_pkg::ST_DIS_A:
            state_in = first_ff ? sal_pkg::ST_DIS_B : sal_pkg::ST_DIS_K;
         sal_pkg::ST_DIS_K:   state_in = sal_pkg::ST_DIS_B;
         sal_pkg::ST_DIS_B:   state_in = sal_pkg::ST_DIS_C;
         sal_pkg::ST_DIS_C: begin
            if (!stat.zero) begin
               state_in = sal_pkg::ST_DIS_A;
            end else begin
               state_in = first_ff ? sal_pkg::ST_RNK_A : sal_pkg::ST_NEW_A;
            end
         end
         sal_pkg::ST_RNK_A:   state_in = sal_pkg::ST_RNK_B;
         sal_pkg::ST_RNK_B:   state_in = sal_pkg::ST_RNK_C;
         sal_pkg::ST_RNK_C:
            state_in = stat.last ? sal_pkg::ST_CHK : sal_pkg::ST_RNK_A;
         sal_pkg::ST_CHK:
            state_in = stat.more_pass ? sal_pkg::ST_SCR_T : sal_pkg::ST_KAS_A;
         sal_pkg::ST_SCR_T:   if (stat.last) state_in = sal_pkg::ST_SCR_A;
         sal_pkg::ST_SCR_A:   state_in = sal_pkg::ST_SCR_B;
         sal_pkg::ST_SCR_B:
            state_in = stat.last ? sal_pkg::ST_CLR : sal_pkg::ST_SCR_A;
         sal_pkg::ST_NEW_A:   state_in = sal_pkg::ST_NEW_B;
         sal_pkg::ST_NEW_B:   state_in = sal_pkg::ST_NEW_C;
         sal_pkg::ST_NEW_C:   state_in = sal_pkg::ST_NEW_D;
         sal_pkg::ST_NEW_D:
            state_in = stat.last ? sal_pkg::ST_CPY_A : sal_pkg::ST_NEW_A;
         sal_pkg::ST_CPY_A:   state_in = sal_pkg::ST_CPY_B;
         sal_pkg::ST_CPY_B:
            state_in = stat.last ? sal_pkg::ST_CHK : sal_pkg::ST_CPY_A;
         sal_pkg::ST_KAS_A:   state_in = sal_pkg::ST_KAS_B;
         sal_pkg::ST_KAS_B: begin
            if (!stat.kas_skip) begin
               state_in = sal_pkg::ST_KAS_J;
            end else begin
               state_in = stat.last ? sal_pkg::ST_KAS_END : sal_pkg::ST_KAS_A;
            end
         end
         sal_pkg::ST_KAS_J:   state_in = sal_pkg::ST_KAS_T1;
         sal_pkg::ST_KAS_T1:
            state_in = stat.kas_more ? sal_pkg::ST_KAS_T2 : sal_pkg::ST_KAS_W;
         sal_pkg::ST_KAS_T2:  state_in = sal_pkg::ST_KAS_T3;
         sal_pkg::ST_KAS_T3:
            state_in = stat.kas_eq ? sal_pkg::ST_KAS_T1 : sal_pkg::ST_KAS_W;
         sal_pkg::ST_KAS_W:
            state_in = stat.last ? sal_pkg::ST_KAS_END : sal_pkg::ST_KAS_A;
         sal_pkg::ST_KAS_END: state_in = sal_pkg::ST_IDLE;
         default:             state_in = sal_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      first_in = first_ff;
      if (state_ff == sal_pkg::ST_INIT) begin
         first_in = 1'b1;
      end else if (state_ff == sal_pkg::ST_CHK) begin
         first_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sal_pkg::ST_IDLE;
         first_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         first_ff <= first_in;
      end
   end

   always_comb begin
      cmd.step      = state_ff;
      cmd.first     = first_ff;
      cmd.req_ready = (state_ff == sal_pkg::ST_IDLE);
   end

endmodule

// ===== hdl/sal_datapath.sv =====
module sal_datapath #(
   parameter int MAX_LEN      = sal_pkg::DEF_MAX_LEN,
   parameter int TOKEN_VALUES = sal_pkg::DEF_TOKEN_VALUES
) (
   input  logic                clock,
   input  logic                reset,
   sal_req_if.sink             req_bus,
   sal_rsp_if.source           rsp_bus,
   input  sal_pkg::cmd_type    cmd,
   output sal_pkg::status_type stat
);

   localparam int LEN_W   = $clog2(MAX_LEN);
   localparam int CNT_W   = $clog2(MAX_LEN + 1);
   localparam int KW      = CNT_W + 1;
   localparam int BUCKETS = (TOKEN_VALUES > MAX_LEN) ? TOKEN_VALUES : MAX_LEN;
   localparam int BKT_W   = $clog2(BUCKETS);
   localparam int RW      = (LEN_W > 10) ? LEN_W : 10;

   // RAM ports
   logic             tok_we, ord_we, rnk_we, scr_we, pre_we, bkt_we;
   logic [LEN_W-1:0] tok_waddr, tok_raddr, ord_waddr, ord_raddr;
   logic [LEN_W-1:0] rnk_waddr, rnk_raddr, scr_waddr, scr_raddr;
   logic [LEN_W-1:0] pre_waddr, pre_raddr;
   logic [BKT_W-1:0] bkt_waddr, bkt_raddr;
   logic [15:0]      tok_wdata, tok_rdata;
   logic [LEN_W-1:0] ord_wdata, ord_rdata, rnk_wdata, rnk_rdata;
   logic [LEN_W-1:0] scr_wdata, scr_rdata, pre_wdata, pre_rdata;
   logic [CNT_W-1:0] bkt_wdata, bkt_rdata;

   // control and working registers
   logic [CNT_W-1:0] len_ff, len_in;
   logic             done_ff, done_in;
   logic [BKT_W-1:0] i_ff, i_in;
   logic [CNT_W-1:0] cur_ff, cur_in;
   logic [KW-1:0]    k_ff, k_in;
   logic [BKT_W-1:0] key_ff;
   logic [LEN_W-1:0] val_ff;
   logic [CNT_W-1:0] acc_ff, acc_in;
   logic [15:0]      prev_t_ff;
   logic [LEN_W-1:0] prev_r_ff, prev_rb_ff, rb_ff, maxr_ff, r_ff, j_ff;
   logic [CNT_W-1:0] prev_b2_ff, h_ff, h_in;
   logic [15:0]      ti_ff;
   logic [9:0]       rank_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [9:0]       position_ff, common_ff;
   logic             in_range_ff;

   logic             load_acc, read_acc;
   logic [CNT_W-1:0] base;
   logic [15:0]      tok_clamp;
   logic [RW-1:0]    rank_wide;
   logic [31:0]      lim, ipos, jpos, bk, r1, rem_len;
   logic [BKT_W-1:0] key_now;
   logic [CNT_W-1:0] cnt_dec, b2;
   logic [LEN_W-1:0] r_new, new_r;
   logic             scr_keep;

   assign load_acc = req_bus.valid && cmd.req_ready && (req_bus.action == sal_pkg::ACT_LOAD);
   assign read_acc = req_bus.valid && cmd.req_ready && (req_bus.action == sal_pkg::ACT_READ);
   assign req_bus.ready = cmd.req_ready;

   assign base      = done_ff ? '0 : len_ff;
   assign tok_clamp = (32'(req_bus.token) >= 32'(TOKEN_VALUES)) ?
                      16'(TOKEN_VALUES - 1) : req_bus.token;
   assign rank_wide = RW'(rank_ff);
   assign ipos      = 32'(i_ff) + 32'(h_ff);
   assign jpos      = 32'(j_ff) + 32'(h_ff);
   assign bk        = 32'(val_ff) + 32'(k_ff);
   assign r1        = 32'(rnk_rdata) + 32'd1;
   assign rem_len   = 32'(len_ff) - 32'(k_ff);
   assign key_now   = cmd.first ? BKT_W'(tok_rdata) : BKT_W'(rnk_rdata);
   assign cnt_dec   = bkt_rdata - CNT_W'(1);
   assign b2        = (bk < 32'(len_ff)) ? (CNT_W'(rnk_rdata) + CNT_W'(1)) : '0;
   assign r_new     = stat.zero ? '0 :
                      prev_r_ff + LEN_W'(tok_rdata != prev_t_ff);
   assign new_r     = stat.zero ? '0 :
                      prev_r_ff + LEN_W'((rb_ff != prev_rb_ff) || (b2 != prev_b2_ff));
   assign scr_keep  = (32'(ord_rdata) >= 32'(k_ff));

   always_comb begin
      lim = 32'(len_ff);
      if (cmd.first && (cmd.step == sal_pkg::ST_CLR || cmd.step == sal_pkg::ST_SUM_A ||
                        cmd.step == sal_pkg::ST_SUM_B)) begin
         lim = 32'(BUCKETS);
      end
   end

   always_comb begin
      stat.req_valid  = req_bus.valid;
      stat.req_action = req_bus.action;
      stat.req_eos    = req_bus.end_of_string;
      stat.rsp_free   = !rsp_valid_ff || rsp_bus.ready;
      stat.last       = (32'(i_ff) == lim - 32'd1);
      stat.zero       = (i_ff == '0);
      stat.more_pass  = (32'(k_ff) < 32'(len_ff)) &&
                        (32'(maxr_ff) != 32'(len_ff) - 32'd1);
      stat.kas_skip   = (r1 >= 32'(len_ff));
      stat.kas_more   = (ipos < 32'(len_ff)) && (jpos < 32'(len_ff));
      stat.kas_eq     = (tok_rdata == ti_ff);
   end

   // token store
   always_comb begin
      tok_we    = load_acc && (32'(base) < 32'(MAX_LEN));
      tok_waddr = base[LEN_W-1:0];
      tok_wdata = tok_clamp;
      case (cmd.step)
         sal_pkg::ST_RNK_B:  tok_raddr = ord_rdata;
         sal_pkg::ST_KAS_T1: tok_raddr = ipos[LEN_W-1:0];
         sal_pkg::ST_KAS_T2: tok_raddr = jpos[LEN_W-1:0];
         default:            tok_raddr = i_ff[LEN_W-1:0];
      endcase
   end

   // order store
   always_comb begin
      ord_we    = (cmd.step == sal_pkg::ST_DIS_C);
      ord_waddr = cnt_dec[LEN_W-1:0];
      ord_wdata = val_ff;
      case (cmd.step)
         sal_pkg::ST_KAS_B:   ord_raddr = r1[LEN_W-1:0];
         sal_pkg::ST_RD_ADDR,
         sal_pkg::ST_RD_DATA: ord_raddr = rank_wide[LEN_W-1:0];
         default:             ord_raddr = i_ff[LEN_W-1:0];
      endcase
   end

   // rank store
   always_comb begin
      rnk_we    = 1'b0;
      rnk_waddr = val_ff;
      rnk_wdata = r_new;
      case (cmd.step)
         sal_pkg::ST_RNK_C: rnk_we = 1'b1;
         sal_pkg::ST_CPY_B: begin
            rnk_we    = 1'b1;
            rnk_waddr = i_ff[LEN_W-1:0];
            rnk_wdata = pre_rdata;
         end
         default: rnk_we = 1'b0;
      endcase
      case (cmd.step)
         sal_pkg::ST_CNT_K,
         sal_pkg::ST_DIS_K: rnk_raddr = scr_rdata;
         sal_pkg::ST_NEW_B: rnk_raddr = ord_rdata;
         sal_pkg::ST_NEW_C: rnk_raddr = bk[LEN_W-1:0];
         default:           rnk_raddr = i_ff[LEN_W-1:0];
      endcase
   end

   // scratch store
   always_comb begin
      scr_waddr = cur_ff[LEN_W-1:0];
      scr_raddr = i_ff[LEN_W-1:0];
      scr_we    = 1'b0;
      scr_wdata = i_ff[LEN_W-1:0];
      case (cmd.step)
         sal_pkg::ST_SCR_T: scr_we = 1'b1;
         sal_pkg::ST_SCR_B: begin
            scr_we    = scr_keep;
            scr_wdata = LEN_W'(32'(ord_rdata) - 32'(k_ff));
         end
         default: scr_we = 1'b0;
      endcase
   end

   // prefix store: new ranks during a pass, LCP values at the end
   always_comb begin
      pre_we    = 1'b0;
      pre_waddr = val_ff;
      pre_wdata = new_r;
      case (cmd.step)
         sal_pkg::ST_NEW_D: pre_we = 1'b1;
         sal_pkg::ST_KAS_W: begin
            pre_we    = 1'b1;
            pre_waddr = r_ff;
            pre_wdata = LEN_W'(h_ff);
         end
         sal_pkg::ST_KAS_END: begin
            pre_we    = 1'b1;
            pre_waddr = LEN_W'(32'(len_ff) - 32'd1);
            pre_wdata = '0;
         end
         default: pre_we = 1'b0;
      endcase
      case (cmd.step)
         sal_pkg::ST_RD_ADDR,
         sal_pkg::ST_RD_DATA: pre_raddr = rank_wide[LEN_W-1:0];
         default:             pre_raddr = i_ff[LEN_W-1:0];
      endcase
   end

   // bucket counts
   always_comb begin
      bkt_we    = 1'b0;
      bkt_waddr = i_ff;
      bkt_wdata = '0;
      case (cmd.step)
         sal_pkg::ST_CLR: bkt_we = 1'b1;
         sal_pkg::ST_CNT_C: begin
            bkt_we    = 1'b1;
            bkt_waddr = key_ff;
            bkt_wdata = bkt_rdata + CNT_W'(1);
         end
         sal_pkg::ST_SUM_B: begin
            bkt_we    = 1'b1;
            bkt_wdata = acc_in;
         end
         sal_pkg::ST_DIS_C: begin
            bkt_we    = 1'b1;
            bkt_waddr = key_ff;
            bkt_wdata = cnt_dec;
         end
         default: bkt_we = 1'b0;
      endcase
      case (cmd.step)
         sal_pkg::ST_CNT_B,
         sal_pkg::ST_DIS_B: bkt_raddr = key_now;
         default:           bkt_raddr = i_ff;
      endcase
   end

   // loop counters and length bookkeeping
   always_comb begin
      i_in    = i_ff;
      cur_in  = cur_ff;
      k_in    = k_ff;
      h_in    = h_ff;
      acc_in  = acc_ff;
      len_in  = len_ff;
      done_in = done_ff;
      if (load_acc) begin
         done_in = 1'b0;
         len_in  = tok_we ? (base + CNT_W'(1)) : base;
      end
      case (cmd.step)
         sal_pkg::ST_INIT: begin
            i_in = '0;
            k_in = KW'(1);
         end
         sal_pkg::ST_CLR: begin
            acc_in = '0;
            i_in   = stat.last ? '0 : i_ff + BKT_W'(1);
         end
         sal_pkg::ST_CNT_C, sal_pkg::ST_RNK_C, sal_pkg::ST_NEW_D: begin
            i_in = stat.last ? '0 : i_ff + BKT_W'(1);
         end
         sal_pkg::ST_SCR_T: begin
            cur_in = cur_ff + CNT_W'(1);
            i_in   = stat.last ? '0 : i_ff + BKT_W'(1);
         end
         sal_pkg::ST_SCR_B: begin
            if (scr_keep) cur_in = cur_ff + CNT_W'(1);
            i_in = stat.last ? '0 : i_ff + BKT_W'(1);
         end
         sal_pkg::ST_SUM_B: begin
            acc_in = acc_ff + bkt_rdata;
            i_in   = stat.last ? BKT_W'(32'(len_ff) - 32'd1) : i_ff + BKT_W'(1);
         end
         sal_pkg::ST_DIS_C: i_in = stat.zero ? '0 : i_ff - BKT_W'(1);
         sal_pkg::ST_CHK: begin
            cur_in = '0;
            h_in   = '0;
            i_in   = stat.more_pass ? BKT_W'(rem_len) : '0;
         end
         sal_pkg::ST_CPY_B: begin
            if (stat.last) k_in = k_ff << 1;
            i_in = stat.last ? '0 : i_ff + BKT_W'(1);
         end
         sal_pkg::ST_KAS_B: begin
            if (stat.kas_skip) begin
               h_in = '0;
               i_in = i_ff + BKT_W'(1);
            end
         end
         sal_pkg::ST_KAS_T3: if (stat.kas_eq) h_in = h_ff + CNT_W'(1);
         sal_pkg::ST_KAS_W: begin
            if (h_ff != '0) h_in = h_ff - CNT_W'(1);
            i_in = i_ff + BKT_W'(1);
         end
         sal_pkg::ST_KAS_END: done_in = 1'b1;
         default: i_in = i_ff;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.step == sal_pkg::ST_RD_DATA && stat.rsp_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff   <= i_in;
      cur_ff <= cur_in;
      k_ff   <= k_in;
      h_ff   <= h_in;
      acc_ff <= acc_in;
      if (read_acc) rank_ff <= req_bus.rank;
      case (cmd.step)
         sal_pkg::ST_CNT_B: key_ff <= key_now;
         sal_pkg::ST_DIS_K: val_ff <= scr_rdata;
         sal_pkg::ST_DIS_B: begin
            key_ff <= key_now;
            if (cmd.first) val_ff <= i_ff[LEN_W-1:0];
         end
         sal_pkg::ST_RNK_B, sal_pkg::ST_NEW_B: val_ff <= ord_rdata;
         sal_pkg::ST_RNK_C: begin
            prev_t_ff <= tok_rdata;
            prev_r_ff <= r_new;
            maxr_ff   <= r_new;
         end
         sal_pkg::ST_NEW_C: rb_ff <= rnk_rdata;
         sal_pkg::ST_NEW_D: begin
            prev_r_ff  <= new_r;
            prev_rb_ff <= rb_ff;
            prev_b2_ff <= b2;
            maxr_ff    <= new_r;
         end
         sal_pkg::ST_KAS_B: r_ff <= rnk_rdata;
         sal_pkg::ST_KAS_J: j_ff <= ord_rdata;
         sal_pkg::ST_KAS_T2: ti_ff <= tok_rdata;
         default: ;
      endcase
      if (cmd.step == sal_pkg::ST_RD_DATA && stat.rsp_free) begin
         if (done_ff && (32'(rank_ff) < 32'(len_ff))) begin
            position_ff <= 10'(ord_rdata);
            common_ff   <= 10'(pre_rdata);
            in_range_ff <= 1'b1;
         end else begin
            position_ff <= '0;
            common_ff   <= '0;
            in_range_ff <= 1'b0;
         end
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.position      = position_ff;
   assign rsp_bus.common_prefix = common_ff;
   assign rsp_bus.in_range      = in_range_ff;

   sal_ram #(.WIDTH(16), .DEPTH(MAX_LEN)) u_tok (
      .clock(clock), .we(tok_we), .waddr(tok_waddr), .wdata(tok_wdata),
      .raddr(tok_raddr), .rdata(tok_rdata));
   sal_ram #(.WIDTH(LEN_W), .DEPTH(MAX_LEN)) u_ord (
      .clock(clock), .we(ord_we), .waddr(ord_waddr), .wdata(ord_wdata),
      .raddr(ord_raddr), .rdata(ord_rdata));
   sal_ram #(.WIDTH(LEN_W), .DEPTH(MAX_LEN)) u_rnk (
      .clock(clock), .we(rnk_we), .waddr(rnk_waddr), .wdata(rnk_wdata),
      .raddr(rnk_raddr), .rdata(rnk_rdata));
   sal_ram #(.WIDTH(LEN_W), .DEPTH(MAX_LEN)) u_scr (
      .clock(clock), .we(scr_we), .waddr(scr_waddr), .wdata(scr_wdata),
      .raddr(scr_raddr), .rdata(scr_rdata));
   sal_ram #(.WIDTH(LEN_W), .DEPTH(MAX_LEN)) u_pre (
      .clock(clock), .we(pre_we), .waddr(pre_waddr), .wdata(pre_wdata),
      .raddr(pre_raddr), .rdata(pre_rdata));
   sal_ram #(.WIDTH(CNT_W), .DEPTH(BUCKETS)) u_bkt (
      .clock(clock), .we(bkt_we), .waddr(bkt_waddr), .wdata(bkt_wdata),
      .raddr(bkt_raddr), .rdata(bkt_rdata));

endmodule

// ===== hdl/suffix_array_lcp_builder.sv =====
// Channel   Dir  Payload                                   Transaction
// req_bus   in   action, token, end_of_string, rank        valid && ready
// rsp_bus   out  position, common_prefix, in_range         valid && ready
//
// A load is taken while idle; a read goes through a RAM read, then the output register.
// A load with end_of_string starts a build, paced by RAM accesses: a token pass,
// then doubling passes, then the LCP sweep over every suffix.
// Reset is synchronous; it clears the controller state, the length, done flag and output valid.
// A waiting result does not block loads; a read waits for the output register.
module suffix_array_lcp_builder #(
   parameter int MAX_LEN      = sal_pkg::DEF_MAX_LEN,
   parameter int TOKEN_VALUES = sal_pkg::DEF_TOKEN_VALUES
) (
   input logic       clock,
   input logic       reset,
   sal_req_if.sink   req_bus,
   sal_rsp_if.source rsp_bus
);

   sal_pkg::cmd_type    cmd;
   sal_pkg::status_type stat;

   sal_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .stat (stat),
      .cmd  (cmd)
   );

   sal_datapath #(
      .MAX_LEN     (MAX_LEN),
      .TOKEN_VALUES(TOKEN_VALUES)
   ) u_datapath (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .cmd    (cmd),
      .stat   (stat)
   );

endmodule
